// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/core/ssb_pkg.sv =====
// ----------------------------------------------------------------------------
// ssb_pkg
// Constants, types and control structs of the scaled sprite blitter.
// ----------------------------------------------------------------------------
package ssb_pkg;

  // Default geometry
  localparam int SHEET_WIDTH_DEF   = 128;
  localparam int SHEET_HEIGHT_DEF  = 64;
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  // Low-resolution view edge, centered on the square grid
  localparam int LOWRES = 128;

  // Sprite scan
  localparam int SPRITE_PIX = 64;
  localparam int PIX_W      = 6;
  localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(SPRITE_PIX - 1);

  // Field widths
  localparam int ADDR_IN_W = 13;
  localparam int COLOR_W   = 4;
  localparam int NUM_W     = 8;
  localparam int POS_W     = 10;
  localparam int SQ_COL_W  = 8;
  localparam int SQ_ROW_W  = 7;
  localparam int COORD_W   = 12;
  localparam int LIN_W     = 16;
  localparam int REMAP_W   = 64;

  // Request kinds on in_tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // Register map
  localparam int  CFG_ADDR_W      = 4;
  localparam int  CFG_DATA_W      = 64;
  localparam logic REG_COLOR_REMAP = 1'b0;
  localparam logic [REMAP_W-1:0] REMAP_RESET = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_t;

  typedef struct packed {
    logic             capture;  // latch a draw request
    logic             load;     // write one sheet pixel
    logic             issue;    // start one pixel read
    logic [PIX_W-1:0] pix;      // pixel index in destination order
    logic             last;     // final pixel of the draw
  } cmd_t;

  typedef struct packed {
    logic slot_free;            // read stage can take a new pixel
  } stat_t;

endpackage

// ===== rtl/core/scaled_sprite_blitter_top.sv =====
// ----------------------------------------------------------------------------
// scaled_sprite_blitter_top
// Sprite sheet store and 8x8 sprite drawer at double scale with color remap.
// ----------------------------------------------------------------------------
//
//  Port group | Direction | Moves
//  -----------+-----------+------------------------------------------------
//  in_*       | slave     | load request (one sheet pixel) or draw request
//  out_*      | master    | one 2x2 square per source pixel, 64 per draw
//  cfg_*      | slave     | color_remap register at byte address 0
//
//  A load request writes one sheet pixel; a draw is accepted, then issues its 64
//  pixels, one sheet read per pixel, through the read stage and result register.
//  A stalled out_tready holds the result register, then the read stage, then
//  the pixel sequencer; nothing is dropped. in_tready is low while a draw is
//  issued and high again while its last results drain. Reset clears control
//  state and loads the identity remap; the sheet RAM is never cleared.
//
module scaled_sprite_blitter_top #(
  parameter int SHEET_WIDTH   = ssb_pkg::SHEET_WIDTH_DEF,
  parameter int SHEET_HEIGHT  = ssb_pkg::SHEET_HEIGHT_DEF,
  parameter int SCREEN_WIDTH  = ssb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ssb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [12:0] sheet_address, [16:13] sheet_value, [24:17] sprite_number,
  // [34:25] pos_x, [44:35] pos_y, [45] flip_x, [46] flip_y, [47] zero
  input  logic [47:0]                       in_tdata,
  // [0] mode
  input  logic                              in_tuser,
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] square_column, [14:8] square_row, [18:15] color, [23:19] zero
  output logic [23:0]                       out_tdata,
  // [0] write_enable
  output logic                              out_tuser,
  output logic                              out_tlast,
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ssb_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ssb_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ssb_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  ssb_pkg::cmd_t                     cmd;
  ssb_pkg::stat_t                    stat;
  logic [ssb_pkg::REMAP_W-1:0]       remap_r;
  logic                              cfg_wr;
  logic                              reg_hit;
  logic                              res_we;
  logic [ssb_pkg::SQ_COL_W-1:0]      res_col;
  logic [ssb_pkg::SQ_ROW_W-1:0]      res_row;
  logic [ssb_pkg::COLOR_W-1:0]       res_color;

  // Register decode: one 64-bit register, selected by the 8-byte slot
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[ssb_pkg::CFG_ADDR_W-1] == ssb_pkg::REG_COLOR_REMAP);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_hit ? remap_r : '0;

  // Hold the remap table; write it only on a completed access to its slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_r <= ssb_pkg::REMAP_RESET;
    end else if (cfg_wr && reg_hit) begin
      remap_r <= cfg_pwdata;
    end
  end

  // Sequencer: accepts requests, steps pixel index while the read stage is free
  ssb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: sheet RAM, sheet and screen clipping, remap, result register
  ssb_datapath #(
    .SHEET_WIDTH   (SHEET_WIDTH),
    .SHEET_HEIGHT  (SHEET_HEIGHT),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .sheet_address (in_tdata[12:0]),
    .sheet_value   (in_tdata[16:13]),
    .sprite_number (in_tdata[24:17]),
    .pos_x         (in_tdata[34:25]),
    .pos_y         (in_tdata[44:35]),
    .flip_x        (in_tdata[45]),
    .flip_y        (in_tdata[46]),
    .remap         (remap_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_we        (res_we),
    .out_col       (res_col),
    .out_row       (res_row),
    .out_color     (res_color),
    .out_last      (out_tlast)
  );

  // Pack the result fields, lowest field first, zero fill to whole bytes
  assign out_tdata = {5'b00000, res_color, res_row, res_col};
  assign out_tuser = res_we;

endmodule

// ===== rtl/core/ssb_ram.sv =====
// ----------------------------------------------------------------------------
// ssb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ssb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssb_ctrl
// Request sequencer: takes loads and draws, steps the 64 pixels of a draw.
// ----------------------------------------------------------------------------
module ssb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  input  ssb_pkg::stat_t stat,
  output ssb_pkg::cmd_t  cmd
);

  ssb_pkg::state_t                state_r, state_nxt;
  logic [ssb_pkg::PIX_W-1:0]      pix_r, pix_nxt;
  logic                           accept;

  assign in_ready = (state_r == ssb_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    pix_nxt     = pix_r;
    cmd         = '0;
    cmd.pix     = pix_r;
    cmd.last    = (pix_r == ssb_pkg::PIX_LAST);
    unique case (state_r)
      ssb_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == ssb_pkg::MODE_DRAW) begin
            cmd.capture = 1'b1;
            pix_nxt     = '0;
            state_nxt   = ssb_pkg::ST_DRAW;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ssb_pkg::ST_DRAW: begin
        if (stat.slot_free) begin
          cmd.issue = 1'b1;
          if (pix_r == ssb_pkg::PIX_LAST) begin
            pix_nxt   = '0;
            state_nxt = ssb_pkg::ST_IDLE;
          end else begin
            pix_nxt = pix_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ssb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssb_pkg::ST_IDLE;
      pix_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pix_r   <= pix_nxt;
    end
  end

endmodule

// ===== rtl/core/ssb_datapath.sv =====
// ----------------------------------------------------------------------------
// ssb_datapath
// Sheet memory, address and clip math, remap and the result register.
// ----------------------------------------------------------------------------
module ssb_datapath #(
  parameter int SHEET_WIDTH   = ssb_pkg::SHEET_WIDTH_DEF,
  parameter int SHEET_HEIGHT  = ssb_pkg::SHEET_HEIGHT_DEF,
  parameter int SCREEN_WIDTH  = ssb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ssb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssb_pkg::cmd_t                       cmd,
  output ssb_pkg::stat_t                      stat,
  input  logic [ssb_pkg::ADDR_IN_W-1:0]       sheet_address,
  input  logic [ssb_pkg::COLOR_W-1:0]         sheet_value,
  input  logic [ssb_pkg::NUM_W-1:0]           sprite_number,
  input  logic signed [ssb_pkg::POS_W-1:0]    pos_x,
  input  logic signed [ssb_pkg::POS_W-1:0]    pos_y,
  input  logic                                flip_x,
  input  logic                                flip_y,
  input  logic [ssb_pkg::REMAP_W-1:0]         remap,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_we,
  output logic [ssb_pkg::SQ_COL_W-1:0]        out_col,
  output logic [ssb_pkg::SQ_ROW_W-1:0]        out_row,
  output logic [ssb_pkg::COLOR_W-1:0]         out_color,
  output logic                                out_last
);

  localparam int SHEET_SIZE = SHEET_WIDTH * SHEET_HEIGHT;
  localparam int AW         = $clog2(SHEET_SIZE);
  localparam int SQ_OFS_X   = (SCREEN_WIDTH / 2 - ssb_pkg::LOWRES) / 2;
  localparam int SQ_OFS_Y   = (SCREEN_HEIGHT / 2 - ssb_pkg::LOWRES) / 2;
  localparam int CW         = ssb_pkg::COORD_W;
  localparam logic signed [CW-1:0] OFS_X   = CW'(SQ_OFS_X);
  localparam logic signed [CW-1:0] OFS_Y   = CW'(SQ_OFS_Y);
  localparam logic signed [CW-1:0] COL_LIM = CW'(SCREEN_WIDTH / 2);
  localparam logic signed [CW-1:0] ROW_LIM = CW'(SCREEN_HEIGHT / 2);

  // Held draw request
  logic [ssb_pkg::NUM_W-1:0]        num_r;
  logic signed [ssb_pkg::POS_W-1:0] posx_r, posy_r;
  logic                             fx_r, fy_r;

  // Read stage, aligned with the RAM output
  logic                             s1_valid_r;
  logic                             s1_vis_r;
  logic                             s1_last_r;
  logic [ssb_pkg::SQ_COL_W-1:0]     s1_col_r;
  logic [ssb_pkg::SQ_ROW_W-1:0]     s1_row_r;

  // Result register
  logic                             out_valid_r;
  logic                             out_we_r;
  logic                             out_last_r;
  logic [ssb_pkg::SQ_COL_W-1:0]     out_col_r;
  logic [ssb_pkg::SQ_ROW_W-1:0]     out_row_r;
  logic [ssb_pkg::COLOR_W-1:0]      out_color_r;

  logic [2:0]                       px, py;
  logic [6:0]                       gx, gy;
  logic                             in_sheet;
  logic [ssb_pkg::LIN_W-1:0]        lin;
  logic [AW-1:0]                    rd_addr;
  logic signed [CW-1:0]             col, row;
  logic                             on_screen;
  logic                             out_free;
  logic                             s1_move;
  logic                             load_ok;
  logic [ssb_pkg::COLOR_W-1:0]      raw;
  logic                             pix_we;

  assign px = cmd.pix[2:0];
  assign py = cmd.pix[5:3];

  // Sheet coordinates: sprite cell origin plus the flipped pixel offset
  assign gx = {num_r[3:0], px ^ {3{fx_r}}};
  assign gy = {num_r[7:4], py ^ {3{fy_r}}};

  assign in_sheet = ({2'b00, gx} < 9'(SHEET_WIDTH)) && ({2'b00, gy} < 9'(SHEET_HEIGHT));
  assign lin      = ssb_pkg::LIN_W'(gy) * ssb_pkg::LIN_W'(SHEET_WIDTH)
                  + ssb_pkg::LIN_W'(gx);
  assign rd_addr  = in_sheet ? lin[AW-1:0] : '0;

  assign col       = OFS_X + CW'(posx_r) + CW'({1'b0, px});
  assign row       = OFS_Y + CW'(posy_r) + CW'({1'b0, py});
  assign on_screen = (col >= 0) && (col < COL_LIM) && (row >= 0) && (row < ROW_LIM);

  assign out_free       = !out_valid_r || out_ready;
  assign s1_move        = s1_valid_r && out_free;
  assign stat.slot_free = !s1_valid_r || out_free;

  assign load_ok = ({4'b0000, sheet_address} < 17'(SHEET_SIZE));

  ssb_ram #(
    .WIDTH (ssb_pkg::COLOR_W),
    .DEPTH (SHEET_SIZE)
  ) u_sheet (
    .clk   (clk),
    .we    (cmd.load && load_ok),
    .waddr (AW'(sheet_address)),
    .wdata (sheet_value),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (raw)
  );

  assign pix_we = s1_vis_r && (raw != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r  <= '0;
      posx_r <= '0;
      posy_r <= '0;
      fx_r   <= 1'b0;
      fy_r   <= 1'b0;
    end else if (cmd.capture) begin
      num_r  <= sprite_number;
      posx_r <= pos_x;
      posy_r <= pos_y;
      fx_r   <= flip_x;
      fy_r   <= flip_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.issue) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_vis_r  <= in_sheet && on_screen;
      s1_last_r <= cmd.last;
      s1_col_r  <= col[ssb_pkg::SQ_COL_W-1:0];
      s1_row_r  <= row[ssb_pkg::SQ_ROW_W-1:0];
    end
    if (s1_move) begin
      out_we_r    <= pix_we;
      out_last_r  <= s1_last_r;
      out_col_r   <= pix_we ? s1_col_r : '0;
      out_row_r   <= pix_we ? s1_row_r : '0;
      out_color_r <= pix_we ? remap[{raw, 2'b00} +: ssb_pkg::COLOR_W] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_we    = out_we_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_color = out_color_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/ssb_checker.sv =====
// ----------------------------------------------------------------------------
// ssb_checker
// Port-level checks of the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_pready
);

  // A draw request blocks the request channel while its pixels are issued
  `ASSERT_CLK(a_draw_blocks_input, clk, rst_n,
    (in_tvalid && in_tready && (in_tuser == ssb_pkg::MODE_DRAW)) |=> !in_tready)

  // A square that is not written carries no coordinates and no color
  `ASSERT_NEVER(a_masked_is_zero, clk, rst_n,
    out_tvalid && !out_tuser && (out_tdata != '0))

  // A stalled result keeps its payload
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast)))

  // The register port never inserts wait states
  `ASSERT_NEVER(a_cfg_ready, clk, rst_n, !cfg_pready)

endmodule

bind scaled_sprite_blitter_top ssb_checker u_ssb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

// ===== verif/ssb_checker.sv =====
// ----------------------------------------------------------------------------
// ssb_tb_checker
// Watches the request, result and register channels of the sprite blitter,
// predicts every 2x2 square from its own sheet image and remap copy, and
// compares each accepted result with the oldest predicted square.
// ----------------------------------------------------------------------------
module ssb_tb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [47:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,
  input  logic                           out_tuser,
  input  logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ssb_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input  logic                           cfg_pready,
  output int                             mismatches,
  output int                             squares_pending,
  output int                             squares_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHEET_W    = ssb_pkg::SHEET_WIDTH_DEF;
  localparam int SHEET_H    = ssb_pkg::SHEET_HEIGHT_DEF;
  localparam int SHEET_SIZE = SHEET_W * SHEET_H;
  localparam int SQ_COLS    = ssb_pkg::SCREEN_WIDTH_DEF / 2;
  localparam int SQ_ROWS    = ssb_pkg::SCREEN_HEIGHT_DEF / 2;
  localparam int OFS_X      = (SQ_COLS - ssb_pkg::LOWRES) / 2;
  localparam int OFS_Y      = (SQ_ROWS - ssb_pkg::LOWRES) / 2;
  localparam logic [ssb_pkg::CFG_ADDR_W-1:0] REMAP_ADDR =
    ssb_pkg::CFG_ADDR_W'(8 * ssb_pkg::REG_COLOR_REMAP);

  typedef struct packed {
    logic                         we;
    logic [ssb_pkg::SQ_COL_W-1:0] col;
    logic [ssb_pkg::SQ_ROW_W-1:0] row;
    logic [ssb_pkg::COLOR_W-1:0]  color;
    logic                         last;
  } square_t;

  logic [ssb_pkg::COLOR_W-1:0] sheet_img [SHEET_SIZE];
  logic [ssb_pkg::REMAP_W-1:0] remap_copy;
  square_t                     due_squares [$];
  int                          err_total;
  int                          squares_seen;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_total++;
    $display("ssb_tb_checker: %s got %0h want %0h at square %0d", what, got, want,
             squares_seen);
  endtask

  // Queue the 64 squares of one draw request, in destination scan order.
  function automatic void predict_squares(logic [47:0] req);
    logic [ssb_pkg::NUM_W-1:0]   num;
    logic                        fx;
    logic                        fy;
    logic [ssb_pkg::COLOR_W-1:0] raw;
    int                          x0;
    int                          y0;
    int                          px;
    int                          py;
    int                          gx;
    int                          gy;
    int                          col;
    int                          row;
    square_t                     sq;
    num = req[24:17];
    x0  = int'($signed(req[34:25]));
    y0  = int'($signed(req[44:35]));
    fx  = req[45];
    fy  = req[46];
    for (int k = 0; k < ssb_pkg::SPRITE_PIX; k++) begin
      px  = k % 8;
      py  = k / 8;
      gx  = int'(num % 16) * 8 + (fx ? 7 - px : px);
      gy  = int'(num / 16) * 8 + (fy ? 7 - py : py);
      col = OFS_X + x0 + px;
      row = OFS_Y + y0 + py;
      sq  = '0;
      sq.last = (k == ssb_pkg::SPRITE_PIX - 1);
      // Sheet rows past the bottom are never read; they just clear the enable.
      if (gy < SHEET_H && gx < SHEET_W) begin
        raw = sheet_img[gy * SHEET_W + gx];
        if (raw != 0 && col >= 0 && col < SQ_COLS && row >= 0 && row < SQ_ROWS) begin
          sq.we    = 1'b1;
          sq.col   = ssb_pkg::SQ_COL_W'(col);
          sq.row   = ssb_pkg::SQ_ROW_W'(row);
          sq.color = remap_copy[raw * ssb_pkg::COLOR_W +: ssb_pkg::COLOR_W];
        end
      end
      due_squares.push_back(sq);
    end
  endfunction

  always @(posedge clk) begin
    square_t want;
    if (!rst_n) begin
      remap_copy   = ssb_pkg::REMAP_RESET;
      err_total    = 0;
      squares_seen = 0;
      due_squares.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == REMAP_ADDR) remap_copy = cfg_pwdata;
        end else if (cfg_paddr == REMAP_ADDR && cfg_prdata !== remap_copy) begin
          report_mismatch("remap readback", cfg_prdata, remap_copy);
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser == ssb_pkg::MODE_LOAD) begin
          if (int'(in_tdata[12:0]) < SHEET_SIZE) sheet_img[in_tdata[12:0]] = in_tdata[16:13];
        end else begin
          predict_squares(in_tdata);
        end
      end

      if (out_tvalid && out_tready) begin
        if (due_squares.size() == 0) begin
          report_mismatch("square with none due", {out_tuser, out_tdata}, '0);
        end else begin
          want = due_squares.pop_front();
          if (out_tuser !== want.we)
            report_mismatch("write_enable", out_tuser, want.we);
          if (out_tdata[7:0] !== want.col)
            report_mismatch("square_column", out_tdata[7:0], want.col);
          if (out_tdata[14:8] !== want.row)
            report_mismatch("square_row", out_tdata[14:8], want.row);
          if (out_tdata[18:15] !== want.color)
            report_mismatch("color", out_tdata[18:15], want.color);
          if (out_tdata[23:19] !== 5'b0)
            report_mismatch("tdata pad", out_tdata[23:19], '0);
          if (out_tlast !== want.last)
            report_mismatch("last", out_tlast, want.last);
          squares_seen++;
        end
      end
    end
    mismatches      <= err_total;
    squares_pending <= due_squares.size();
    squares_checked <= squares_seen;
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the scaled sprite blitter: fills sprites on the
// sheet, draws them with directed and random positions and flips under several
// remap settings, with random idling on both streams and one long sink stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHEET_W          = ssb_pkg::SHEET_WIDTH_DEF;
  localparam int SHEET_SIZE       = SHEET_W * ssb_pkg::SHEET_HEIGHT_DEF;
  localparam int PIX              = ssb_pkg::SPRITE_PIX;
  localparam int IDLE_PCT         = 18;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS      = 35;
  localparam logic [ssb_pkg::CFG_ADDR_W-1:0] REMAP_ADDR =
    ssb_pkg::CFG_ADDR_W'(8 * ssb_pkg::REG_COLOR_REMAP);

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [47:0]                    in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [23:0]                    out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [ssb_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  int mismatches;
  int squares_pending;
  int squares_checked;

  // Stimulus bookkeeping: which sheet entries hold a value, and which sprites
  // above the sheet bottom are fully written and so safe to draw.
  bit written_map [SHEET_SIZE];
  bit ready_flag [128];
  int ready_list [$];
  int loads_sent;
  int draws_sent;

  // Shared between the sender and the sink process.
  bit calm;
  bit stall_sink;
  bit sink_stall_done;

  scaled_sprite_blitter_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ssb_tb_checker square_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .mismatches      (mismatches),
    .squares_pending (squares_pending),
    .squares_checked (squares_checked)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Sheet index of pixel pix (row-major 8x8) of sprite num.
  function automatic int sprite_addr(int num, int pix);
    return ((num / 16) * 8 + pix / 8) * SHEET_W + (num % 16) * 8 + pix % 8;
  endfunction

  // Pack one request: fields from the lowest bit up, top pad bit held at zero.
  function automatic logic [47:0] pack_request(logic [ssb_pkg::ADDR_IN_W-1:0] addr,
                                               logic [ssb_pkg::COLOR_W-1:0] val,
                                               logic [ssb_pkg::NUM_W-1:0] num,
                                               logic [ssb_pkg::POS_W-1:0] x,
                                               logic [ssb_pkg::POS_W-1:0] y,
                                               logic fx, logic fy);
    return {1'b0, fy, fx, y, x, num, val, addr};
  endfunction

  // Offer one request, idling at random first; return once it is accepted.
  task automatic push_request(logic mode, logic [47:0] data);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Write one sheet pixel; the unused draw fields carry random noise.
  task automatic send_load(int addr, logic [ssb_pkg::COLOR_W-1:0] val);
    int num;
    bit full;
    push_request(ssb_pkg::MODE_LOAD,
                 pack_request(ssb_pkg::ADDR_IN_W'(addr), val, ssb_pkg::NUM_W'($urandom),
                              ssb_pkg::POS_W'($urandom), ssb_pkg::POS_W'($urandom),
                              1'($urandom), 1'($urandom)));
    loads_sent++;
    written_map[addr] = 1'b1;
    num  = (addr / SHEET_W / 8) * 16 + (addr % SHEET_W) / 8;
    full = 1'b1;
    for (int p = 0; p < PIX; p++)
      if (!written_map[sprite_addr(num, p)]) full = 1'b0;
    if (full && !ready_flag[num]) begin
      ready_flag[num] = 1'b1;
      ready_list.push_back(num);
    end
  endtask

  task automatic send_draw(int num, int x, int y, logic fx, logic fy);
    push_request(ssb_pkg::MODE_DRAW,
                 pack_request(ssb_pkg::ADDR_IN_W'($urandom), ssb_pkg::COLOR_W'($urandom),
                              ssb_pkg::NUM_W'(num), ssb_pkg::POS_W'(x),
                              ssb_pkg::POS_W'(y), fx, fy));
    draws_sent++;
  endtask

  // Mostly colored pixels, with a fair share of transparent ones.
  function automatic logic [ssb_pkg::COLOR_W-1:0] pick_color();
    return ($urandom_range(4) == 0) ? ssb_pkg::COLOR_W'(0)
                                    : ssb_pkg::COLOR_W'($urandom_range(15));
  endfunction

  // One APB transfer to the remap register: setup cycle, then access cycle.
  task automatic cfg_access(logic write, logic [ssb_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= REMAP_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drain every due square, let a trailing load settle, then swap the remap
  // and read it back.
  task automatic retune_remap(logic [ssb_pkg::CFG_DATA_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (squares_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_access(1'b1, value);
    @(posedge clk);
    cfg_access(1'b0, '0);
  endtask

  // Sink: random back-pressure, no idling while calm, and one long hold-off
  // counted here so the block backs up into its request port.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_sink && !sink_stall_done) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_stall_done = 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    logic [ssb_pkg::CFG_DATA_W-1:0] remap_plan [4];
    int fill_targets [5];
    int fill_idx;
    int fill_pix;
    int num;
    int x;
    int y;

    remap_plan   = '{64'h0, {ssb_pkg::CFG_DATA_W{1'b1}}, 64'h0123_4567_89AB_CDEF,
                     {$urandom, $urandom}};
    fill_targets = '{17, 112, 63, 64, 90};
    fill_idx     = 0;
    fill_pix     = 0;
    loads_sent   = 0;
    draws_sent   = 0;
    calm            = 1'b0;
    stall_sink      = 1'b0;
    sink_stall_done = 1'b0;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= ssb_pkg::MODE_LOAD;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the first and last sprite above the sheet bottom.
    for (int p = 0; p < PIX; p++) send_load(sprite_addr(0, p), pick_color());
    for (int p = 0; p < PIX; p++) send_load(sprite_addr(127, p), pick_color());

    // Directed: extreme load values and addresses, then every flip, far
    // off-screen positions, sprites below the sheet bottom, partial clips
    // on each edge, exact top-left and bottom-right corners. Reset remap.
    send_load(0, 4'hF);
    send_load(SHEET_SIZE - 1, 4'h0);
    send_load(sprite_addr(0, 9), 4'h0);
    send_draw(0, 0, 0, 1'b0, 1'b0);
    send_draw(0, 0, 0, 1'b1, 1'b0);
    send_draw(0, 0, 0, 1'b0, 1'b1);
    send_draw(0, 0, 0, 1'b1, 1'b1);
    send_draw(127, -512, -512, 1'b0, 1'b0);
    send_draw(127, 511, 511, 1'b1, 1'b1);
    send_draw(128, 10, 10, 1'b0, 1'b0);
    send_draw(255, 20, 20, 1'b1, 1'b1);
    send_draw(127, -20, 2, 1'b0, 1'b1);
    send_draw(0, 140, 118, 1'b1, 1'b0);
    send_draw(0, -16, 4, 1'b0, 1'b0);
    send_draw(127, 136, 116, 1'b0, 1'b0);

    // Random phases, one remap setting each. Phase one carries the long sink
    // stall, phase two runs without any idling.
    for (int ph = 0; ph < 4; ph++) begin
      retune_remap(remap_plan[ph]);
      stall_sink = (ph == 1);
      calm       = (ph == 2);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 50) begin
          // Draw: mostly sprites known to be fully written, some below the
          // sheet bottom, whose squares are never written.
          if ($urandom_range(99) < 25) num = $urandom_range(255, 128);
          else num = ready_list[$urandom_range(ready_list.size() - 1)];
          if ($urandom_range(99) < 70) begin
            x = int'($urandom_range(176)) - 24;
            y = int'($urandom_range(140)) - 12;
          end else begin
            x = int'($urandom_range(1023));
            y = int'($urandom_range(1023));
          end
          send_draw(num, x, y, 1'($urandom), 1'($urandom));
        end else begin
          case ($urandom_range(2))
            0: begin
              // Advance the fill of the next sprite to be made drawable.
              if (fill_idx < 5) begin
                send_load(sprite_addr(fill_targets[fill_idx], fill_pix), pick_color());
                fill_pix++;
                if (fill_pix == PIX) begin
                  fill_pix = 0;
                  fill_idx++;
                end
              end else begin
                send_load(int'($urandom_range(SHEET_SIZE - 1)), pick_color());
              end
            end
            1: begin
              num = ready_list[$urandom_range(ready_list.size() - 1)];
              send_load(sprite_addr(num, $urandom_range(PIX - 1)), pick_color());
            end
            default: send_load(int'($urandom_range(SHEET_SIZE - 1)), pick_color());
          endcase
        end
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then give the pipeline time to show any stray square.
    @(posedge clk);
    while (squares_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run: %0d sheet loads, %0d sprite draws, %0d squares compared",
             loads_sent, draws_sent, squares_checked);
    $display("run: reset, zero, all-ones, reversed and random remaps; %0d drawable sprites",
             ready_list.size());
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ssb_pkg.sv
rtl/core/ssb_ram.sv
rtl/core/ssb_ctrl.sv
rtl/core/ssb_datapath.sv
rtl/core/scaled_sprite_blitter_top.sv
rtl/core/ssb_checker.sv
verif/ssb_checker.sv
verif/tb_top.sv
